FILE: design/wia_pkg.sv
// shared types and constants for the 128-bit unsigned alu
package wia_pkg;

  localparam int unsigned HALF_W = 64;
  localparam int unsigned WIDE_W = 2 * HALF_W;
  localparam int unsigned PART_W = HALF_W / 2;
  localparam int unsigned MODE_W = 4;
  localparam int unsigned SHAMT_W = 8;

  // operation codes carried in the mode field
  typedef enum logic [MODE_W-1:0] {
    MODE_ADD = 4'd0,
    MODE_SUB = 4'd1,
    MODE_MUL = 4'd2,
    MODE_SHL = 4'd3,
    MODE_SHR = 4'd4,
    MODE_AND = 4'd5,
    MODE_OR  = 4'd6,
    MODE_XOR = 4'd7,
    MODE_NOT = 4'd8,
    MODE_NEG = 4'd9,
    MODE_INC = 4'd10,
    MODE_DEC = 4'd11,
    MODE_CMP = 4'd12
  } mode_t;

  // compare flags that travel with every transaction
  typedef struct packed {
    logic less;
    logic equal;
    logic greater;
    logic top_bit_clear;
  } flags_t;

  // stage load enables from the pipeline control
  typedef struct packed {
    logic en1;
    logic en2;
  } adv_t;

endpackage

FILE: design/wia_in_if.sv
// operand channel: valid/ready handshake with the operand payload
interface wia_in_if;
  logic                             valid;
  logic                             ready;
  logic [wia_pkg::MODE_W-1:0]       mode;
  logic [wia_pkg::HALF_W-1:0]       a_high;
  logic [wia_pkg::HALF_W-1:0]       a_low;
  logic [wia_pkg::HALF_W-1:0]       b_high;
  logic [wia_pkg::HALF_W-1:0]       b_low;
  logic [wia_pkg::SHAMT_W-1:0]      shift_amount;

  modport source (
    output valid, mode, a_high, a_low, b_high, b_low, shift_amount,
    input  ready
  );

  modport sink (
    input  valid, mode, a_high, a_low, b_high, b_low, shift_amount,
    output ready
  );
endinterface

FILE: design/wia_out_if.sv
// result channel: valid/ready handshake with the result payload
interface wia_out_if;
  logic                        valid;
  logic                        ready;
  logic [wia_pkg::HALF_W-1:0]  result_high;
  logic [wia_pkg::HALF_W-1:0]  result_low;
  logic                        less;
  logic                        equal;
  logic                        greater;
  logic                        top_bit_clear;

  modport source (
    output valid, result_high, result_low, less, equal, greater, top_bit_clear,
    input  ready
  );

  modport sink (
    input  valid, result_high, result_low, less, equal, greater, top_bit_clear,
    output ready
  );
endinterface

FILE: design/wia_mul.sv
// two-stage multiplier datapath: 32x32 partial products, then reduction
module wia_mul (
  input  logic                         clk,
  input  wia_pkg::adv_t                adv,
  input  logic [wia_pkg::HALF_W-1:0]   a_high,
  input  logic [wia_pkg::HALF_W-1:0]   a_low,
  input  logic [wia_pkg::HALF_W-1:0]   b_high,
  input  logic [wia_pkg::HALF_W-1:0]   b_low,
  output logic [wia_pkg::WIDE_W-1:0]   prod_s2,
  output logic [wia_pkg::HALF_W-1:0]   cross_s2
);

  localparam int unsigned PW = wia_pkg::PART_W;
  localparam int unsigned HW = wia_pkg::HALF_W;
  localparam int unsigned WW = wia_pkg::WIDE_W;

  logic [PW-1:0] al0, al1, bl0, bl1, ah0, ah1, bh0, bh1;

  // full products of a_low * b_low
  logic [HW-1:0] p00_nxt, p01_nxt, p10_nxt, p11_nxt;
  logic [HW-1:0] p00_r, p01_r, p10_r, p11_r;
  // low 64 bits of a_high * b_low and a_low * b_high
  logic [HW-1:0] q00_nxt, r00_nxt, q00_r, r00_r;
  logic [PW-1:0] q10_nxt, q01_nxt, r10_nxt, r01_nxt;
  logic [PW-1:0] q10_r, q01_r, r10_r, r01_r;

  logic [WW-1:0] prod_nxt;
  logic [HW-1:0] cross_nxt;
  logic [PW-1:0] cross_mid;

  assign al0 = a_low[PW-1:0];
  assign al1 = a_low[HW-1:PW];
  assign bl0 = b_low[PW-1:0];
  assign bl1 = b_low[HW-1:PW];
  assign ah0 = a_high[PW-1:0];
  assign ah1 = a_high[HW-1:PW];
  assign bh0 = b_high[PW-1:0];
  assign bh1 = b_high[HW-1:PW];

  // stage 1 partial products
  assign p00_nxt = HW'(al0) * HW'(bl0);
  assign p01_nxt = HW'(al0) * HW'(bl1);
  assign p10_nxt = HW'(al1) * HW'(bl0);
  assign p11_nxt = HW'(al1) * HW'(bl1);
  assign q00_nxt = HW'(ah0) * HW'(bl0);
  assign q10_nxt = ah1 * bl0;
  assign q01_nxt = ah0 * bl1;
  assign r00_nxt = HW'(al0) * HW'(bh0);
  assign r10_nxt = al1 * bh0;
  assign r01_nxt = al0 * bh1;

  always_ff @(posedge clk) begin
    if (adv.en1) begin
      p00_r <= p00_nxt;
      p01_r <= p01_nxt;
      p10_r <= p10_nxt;
      p11_r <= p11_nxt;
      q00_r <= q00_nxt;
      q10_r <= q10_nxt;
      q01_r <= q01_nxt;
      r00_r <= r00_nxt;
      r10_r <= r10_nxt;
      r01_r <= r01_nxt;
    end
  end

  // stage 2 reduction of the partial products
  assign prod_nxt = {{HW{1'b0}}, p00_r}
                  + {{PW{1'b0}}, p01_r, {PW{1'b0}}}
                  + {{PW{1'b0}}, p10_r, {PW{1'b0}}}
                  + {p11_r, {HW{1'b0}}};
  assign cross_mid = q10_r + q01_r + r10_r + r01_r;
  assign cross_nxt = q00_r + r00_r + {cross_mid, {PW{1'b0}}};

  always_ff @(posedge clk) begin
    if (adv.en2) begin
      prod_s2  <= prod_nxt;
      cross_s2 <= cross_nxt;
    end
  end

endmodule

FILE: design/wia_ops.sv
// two-stage datapath for add/sub, shifts, logic ops and the compare flags
module wia_ops (
  input  logic                          clk,
  input  wia_pkg::adv_t                 adv,
  input  logic [wia_pkg::MODE_W-1:0]    mode,
  input  logic [wia_pkg::HALF_W-1:0]    a_high,
  input  logic [wia_pkg::HALF_W-1:0]    a_low,
  input  logic [wia_pkg::HALF_W-1:0]    b_high,
  input  logic [wia_pkg::HALF_W-1:0]    b_low,
  input  logic [wia_pkg::SHAMT_W-1:0]   shift_amount,
  output logic [wia_pkg::MODE_W-1:0]    mode_s2,
  output logic [wia_pkg::WIDE_W-1:0]    res_s2,
  output wia_pkg::flags_t               flags_s2
);

  localparam int unsigned WW = wia_pkg::WIDE_W;

  logic [wia_pkg::MODE_W-1:0]  mode_r;
  logic [WW-1:0]               a_r, b_r;
  logic [wia_pkg::SHAMT_W-1:0] sh_r;

  logic [WW-1:0]   add_x, add_y, add_sum;
  logic            add_cin;
  logic [WW-1:0]   res_nxt;
  wia_pkg::flags_t flags_nxt;

  // stage 1 operand register
  always_ff @(posedge clk) begin
    if (adv.en1) begin
      mode_r <= mode;
      a_r    <= {a_high, a_low};
      b_r    <= {b_high, b_low};
      sh_r   <= shift_amount;
    end
  end

  // shared adder operand select
  always_comb begin
    add_x   = a_r;
    add_y   = b_r;
    add_cin = 1'b0;
    case (mode_r)
      wia_pkg::MODE_SUB: begin
        add_y   = ~b_r;
        add_cin = 1'b1;
      end
      wia_pkg::MODE_NEG: begin
        add_x   = ~a_r;
        add_y   = '0;
        add_cin = 1'b1;
      end
      wia_pkg::MODE_INC: begin
        add_y   = '0;
        add_cin = 1'b1;
      end
      wia_pkg::MODE_DEC: begin
        add_y   = '1;
      end
      default: begin
        add_y = b_r;
      end
    endcase
  end

  assign add_sum = add_x + add_y + WW'(add_cin);

  // result select; multiply, compare and unused codes give zero here
  always_comb begin
    case (mode_r)
      wia_pkg::MODE_ADD, wia_pkg::MODE_SUB, wia_pkg::MODE_NEG,
      wia_pkg::MODE_INC, wia_pkg::MODE_DEC: res_nxt = add_sum;
      wia_pkg::MODE_SHL: res_nxt = a_r << sh_r;
      wia_pkg::MODE_SHR: res_nxt = a_r >> sh_r;
      wia_pkg::MODE_AND: res_nxt = a_r & b_r;
      wia_pkg::MODE_OR:  res_nxt = a_r | b_r;
      wia_pkg::MODE_XOR: res_nxt = a_r ^ b_r;
      wia_pkg::MODE_NOT: res_nxt = ~a_r;
      default:           res_nxt = '0;
    endcase
  end

  // unsigned compare flags, reported in every mode
  assign flags_nxt.less          = (a_r < b_r);
  assign flags_nxt.equal         = (a_r == b_r);
  assign flags_nxt.greater       = (a_r > b_r);
  assign flags_nxt.top_bit_clear = ~a_r[WW-1];

  // stage 2 register
  always_ff @(posedge clk) begin
    if (adv.en2) begin
      mode_s2  <= mode_r;
      res_s2   <= res_nxt;
      flags_s2 <= flags_nxt;
    end
  end

endmodule

FILE: design/wide_integer_alu_128.sv
// 128-bit unsigned alu: three register stages, one transaction per cycle unless the result
//   port stalls. a transaction accepted into stage 1 passes the stage 2 register and shows
//   on the result port from the stage 3 register. the multiplier is split into a 32x32
//   partial product stage and a reduction stage; the final high-half add sits in the
//   output stage.
// a stall on the result port holds every stage; a stage with a free slot still fills.
// reset (rst_n low, synchronous) clears the stage valid bits; the data registers are not reset.
module wide_integer_alu_128 (
  input  logic       clk,
  input  logic       rst_n,
  wia_in_if.sink     in_ch,
  wia_out_if.source  out_ch
);

  localparam int unsigned HW = wia_pkg::HALF_W;
  localparam int unsigned WW = wia_pkg::WIDE_W;

  logic v1_r, v2_r, v3_r;
  logic en3;
  wia_pkg::adv_t adv;

  logic [wia_pkg::MODE_W-1:0] mode_s2;
  logic [WW-1:0]              res_s2;
  logic [WW-1:0]              prod_s2;
  logic [HW-1:0]              cross_s2;
  wia_pkg::flags_t            flags_s2;

  logic [HW-1:0]   res_high_nxt, res_low_nxt;
  logic [HW-1:0]   res_high_r, res_low_r;
  wia_pkg::flags_t flags_r;

  // stall control: a stage loads when it is empty or its successor moves
  assign en3     = !v3_r || out_ch.ready;
  assign adv.en2 = !v2_r || en3;
  assign adv.en1 = !v1_r || adv.en2;
  assign in_ch.ready = adv.en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv.en1) begin
        v1_r <= in_ch.valid;
      end
      if (adv.en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
    end
  end

  wia_mul u_mul (
    .clk      (clk),
    .adv      (adv),
    .a_high   (in_ch.a_high),
    .a_low    (in_ch.a_low),
    .b_high   (in_ch.b_high),
    .b_low    (in_ch.b_low),
    .prod_s2  (prod_s2),
    .cross_s2 (cross_s2)
  );

  wia_ops u_ops (
    .clk          (clk),
    .adv          (adv),
    .mode         (in_ch.mode),
    .a_high       (in_ch.a_high),
    .a_low        (in_ch.a_low),
    .b_high       (in_ch.b_high),
    .b_low        (in_ch.b_low),
    .shift_amount (in_ch.shift_amount),
    .mode_s2      (mode_s2),
    .res_s2       (res_s2),
    .flags_s2     (flags_s2)
  );

  // stage 3: finish the product high half and pick the result
  always_comb begin
    if (mode_s2 == wia_pkg::MODE_MUL) begin
      res_high_nxt = prod_s2[WW-1:HW] + cross_s2;
      res_low_nxt  = prod_s2[HW-1:0];
    end else begin
      res_high_nxt = res_s2[WW-1:HW];
      res_low_nxt  = res_s2[HW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      res_high_r <= res_high_nxt;
      res_low_r  <= res_low_nxt;
      flags_r    <= flags_s2;
    end
  end

  // result port
  assign out_ch.valid         = v3_r;
  assign out_ch.result_high   = res_high_r;
  assign out_ch.result_low    = res_low_r;
  assign out_ch.less          = flags_r.less;
  assign out_ch.equal         = flags_r.equal;
  assign out_ch.greater       = flags_r.greater;
  assign out_ch.top_bit_clear = flags_r.top_bit_clear;

endmodule

FILE: bench/tb_wide_integer_alu_128.sv
// self-checking bench for the 128-bit unsigned alu: directed table, random traffic, stalls
module tb_wide_integer_alu_128;
  timeunit 1ns;
  timeprecision 1ps;

  import wia_pkg::*;

  // mode codes the block does not define; they return a zero result
  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 4'd13;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 4'd15;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned LONG_HOLD    = 120;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_IDLE     = 15;

  localparam logic [WIDE_W-1:0] ZERO = '0;
  localparam logic [WIDE_W-1:0] ONE  = 128'd1;
  localparam logic [WIDE_W-1:0] MAXV = '1;
  localparam logic [WIDE_W-1:0] PAT  = 128'h8000_0000_0000_0001_0000_0000_0000_0003;
  localparam logic [WIDE_W-1:0] PAT2 = 128'h7fed_cba9_8765_4321_0123_4567_89ab_cdef;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [HALF_W-1:0]  a_high;
    logic [HALF_W-1:0]  a_low;
    logic [HALF_W-1:0]  b_high;
    logic [HALF_W-1:0]  b_low;
    logic [SHAMT_W-1:0] shift_amount;
  } alu_op_t;

  typedef struct packed {
    logic [HALF_W-1:0] result_high;
    logic [HALF_W-1:0] result_low;
    flags_t            flags;
  } alu_result_t;

  typedef struct {
    alu_op_t     op;
    bit          known;
    alu_result_t res;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n;

  wia_in_if  in_ch ();
  wia_out_if out_ch ();

  wide_integer_alu_128 dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  alu_result_t alu_results_due[$];
  table_row_t  directed_ops[$];
  alu_result_t got, want;

  int unsigned fail_count     = 0;
  int unsigned ops_accepted   = 0;
  int unsigned results_checked = 0;
  bit          tx_steady      = 1'b0;
  bit          rx_steady      = 1'b0;
  bit          rx_hold_req    = 1'b0;

  always #1 clk = ~clk;

  // wide arithmetic done directly at 128 bits
  function automatic alu_result_t alu_compute(alu_op_t op);
    logic [WIDE_W-1:0] a, b, r;
    alu_result_t res;
    a = {op.a_high, op.a_low};
    b = {op.b_high, op.b_low};
    r = '0;
    case (op.mode)
      MODE_ADD: r = a + b;
      MODE_SUB: r = a - b;
      MODE_MUL: r = a * b;
      MODE_SHL: r = a << op.shift_amount;
      MODE_SHR: r = a >> op.shift_amount;
      MODE_AND: r = a & b;
      MODE_OR:  r = a | b;
      MODE_XOR: r = a ^ b;
      MODE_NOT: r = ~a;
      MODE_NEG: r = ZERO - a;
      MODE_INC: r = a + ONE;
      MODE_DEC: r = a - ONE;
      default:  r = '0;
    endcase
    res.result_high         = r[WIDE_W-1:HALF_W];
    res.result_low          = r[HALF_W-1:0];
    res.flags.less          = a < b;
    res.flags.equal         = a == b;
    res.flags.greater       = a > b;
    res.flags.top_bit_clear = ~a[WIDE_W-1];
    return res;
  endfunction

  // operand halves biased toward carry and sign boundaries
  function automatic logic [HALF_W-1:0] pick_half();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return HALF_W'($urandom_range(0, 15));
      3:       return 64'h8000_0000_0000_0000;
      4:       return 64'h7fff_ffff_ffff_ffff;
      5:       return ~HALF_W'($urandom_range(0, 15));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic alu_op_t random_op();
    alu_op_t op;
    if ($urandom_range(0, 31) == 0) begin
      op.mode = MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
    end else begin
      op.mode = MODE_W'($urandom_range(MODE_ADD, MODE_CMP));
    end
    op.a_high = pick_half();
    op.a_low  = pick_half();
    // equal operands and equal high halves exercise the compare paths
    case ($urandom_range(0, 7))
      0: begin
        op.b_high = op.a_high;
        op.b_low  = op.a_low;
      end
      1: begin
        op.b_high = op.a_high;
        op.b_low  = pick_half();
      end
      default: begin
        op.b_high = pick_half();
        op.b_low  = pick_half();
      end
    endcase
    case ($urandom_range(0, 7))
      0:       op.shift_amount = '0;
      1:       op.shift_amount = SHAMT_W'(63 + $urandom_range(0, 2));
      2:       op.shift_amount = SHAMT_W'(127 + $urandom_range(0, 1));
      3:       op.shift_amount = '1;
      default: op.shift_amount = SHAMT_W'($urandom_range(0, 255));
    endcase
    return op;
  endfunction

  // flags literal order: less, equal, greater, top_bit_clear
  task automatic add_row(input logic [MODE_W-1:0] mode, input logic [WIDE_W-1:0] a,
                         input logic [WIDE_W-1:0] b, input logic [SHAMT_W-1:0] sh,
                         input bit known, input logic [WIDE_W-1:0] r, input logic [3:0] fl);
    table_row_t row;
    row.op.mode         = mode;
    row.op.a_high       = a[WIDE_W-1:HALF_W];
    row.op.a_low        = a[HALF_W-1:0];
    row.op.b_high       = b[WIDE_W-1:HALF_W];
    row.op.b_low        = b[HALF_W-1:0];
    row.op.shift_amount = sh;
    row.known           = known;
    row.res.result_high = r[WIDE_W-1:HALF_W];
    row.res.result_low  = r[HALF_W-1:0];
    row.res.flags       = flags_t'(fl);
    directed_ops.push_back(row);
  endtask

  // offer one operand transaction and record what it must produce
  task automatic offer_op(input alu_op_t op, input bit known, input alu_result_t typed);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= op.mode;
    in_ch.a_high       <= op.a_high;
    in_ch.a_low        <= op.a_low;
    in_ch.b_high       <= op.b_high;
    in_ch.b_low        <= op.b_low;
    in_ch.shift_amount <= op.shift_amount;
    do @(posedge clk); while (!in_ch.ready);
    alu_results_due.push_back(known ? typed : alu_compute(op));
    ops_accepted++;
  endtask

  // result side: random stalls, steady stretches, one long hold-off
  initial begin : result_sink
    int unsigned stall;
    out_ch.ready <= 1'b0;
    forever begin
      if (rx_hold_req) begin
        stall       = LONG_HOLD;
        rx_hold_req = 1'b0;
      end else if (rx_steady) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, MAX_IDLE);
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // compare every result transaction with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.result_high         = out_ch.result_high;
      got.result_low          = out_ch.result_low;
      got.flags.less          = out_ch.less;
      got.flags.equal         = out_ch.equal;
      got.flags.greater       = out_ch.greater;
      got.flags.top_bit_clear = out_ch.top_bit_clear;
      if (alu_results_due.size() == 0) begin
        $error("result transaction with nothing outstanding: %h", got);
        fail_count++;
      end else begin
        want = alu_results_due.pop_front();
        if (got.result_high !== want.result_high) begin
          $error("result_high: expected %h, got %h", want.result_high, got.result_high);
          fail_count++;
        end
        if (got.result_low !== want.result_low) begin
          $error("result_low: expected %h, got %h", want.result_low, got.result_low);
          fail_count++;
        end
        if (got.flags.less !== want.flags.less) begin
          $error("less: expected %b, got %b", want.flags.less, got.flags.less);
          fail_count++;
        end
        if (got.flags.equal !== want.flags.equal) begin
          $error("equal: expected %b, got %b", want.flags.equal, got.flags.equal);
          fail_count++;
        end
        if (got.flags.greater !== want.flags.greater) begin
          $error("greater: expected %b, got %b", want.flags.greater, got.flags.greater);
          fail_count++;
        end
        if (got.flags.top_bit_clear !== want.flags.top_bit_clear) begin
          $error("top_bit_clear: expected %b, got %b",
                 want.flags.top_bit_clear, got.flags.top_bit_clear);
          fail_count++;
        end
      end
      results_checked++;
    end
  end

  // run-length guard
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("cycle limit reached with %0d results outstanding", alu_results_due.size());
    $display("wide_integer_alu_128: mismatch");
    $finish;
  end

  initial begin : stimulus
    alu_result_t unused_res;
    unused_res  = '0;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.mode  <= '0;
    in_ch.a_high <= '0;
    in_ch.a_low  <= '0;
    in_ch.b_high <= '0;
    in_ch.b_low  <= '0;
    in_ch.shift_amount <= '0;

    // directed table: typed results where obvious, predictor elsewhere
    add_row(MODE_ADD, ZERO, ZERO, 8'd0, 1'b1, ZERO, 4'b0101);
    add_row(MODE_ADD, MAXV, ONE, 8'd0, 1'b1, ZERO, 4'b0010);
    add_row(MODE_ADD, {64'h0, 64'hffff_ffff_ffff_ffff}, ONE, 8'd0, 1'b0, ZERO, 4'b0000);
    add_row(MODE_SUB, ZERO, ONE, 8'd0, 1'b1, MAXV, 4'b1001);
    add_row(MODE_SUB, {64'd5, 64'd1}, {64'd5, 64'd2}, 8'd0, 1'b0, ZERO, 4'b0000);
    add_row(MODE_MUL, MAXV, MAXV, 8'd0, 1'b1, ONE, 4'b0100);
    add_row(MODE_MUL, 128'h0123_4567_89ab_cdef_fedc_ba98_7654_3210,
            128'h0000_0001_0000_0003_ffff_ffff_0000_0007, 8'd0, 1'b0, ZERO, 4'b0000);
    // shift by zero returns the operand, 128 or more clears it
    add_row(MODE_SHL, PAT, ZERO, 8'd0, 1'b1, PAT, 4'b0010);
    add_row(MODE_SHL, PAT, ZERO, 8'd1, 1'b0, ZERO, 4'b0000);
    add_row(MODE_SHL, PAT, ZERO, 8'd64, 1'b0, ZERO, 4'b0000);
    add_row(MODE_SHL, PAT, ZERO, 8'd127, 1'b0, ZERO, 4'b0000);
    add_row(MODE_SHL, MAXV, MAXV, 8'd128, 1'b1, ZERO, 4'b0100);
    add_row(MODE_SHR, PAT2, MAXV, 8'd0, 1'b1, PAT2, 4'b1001);
    add_row(MODE_SHR, MAXV, ZERO, 8'd63, 1'b0, ZERO, 4'b0000);
    add_row(MODE_SHR, MAXV, ZERO, 8'd255, 1'b1, ZERO, 4'b0010);
    add_row(MODE_AND, PAT, PAT2, 8'd0, 1'b0, ZERO, 4'b0000);
    add_row(MODE_OR, PAT, PAT2, 8'd0, 1'b0, ZERO, 4'b0000);
    add_row(MODE_NOT, ZERO, ZERO, 8'd0, 1'b1, MAXV, 4'b0101);
    add_row(MODE_NEG, ONE, ZERO, 8'd0, 1'b1, MAXV, 4'b0011);
    add_row(MODE_INC, MAXV, MAXV, 8'd0, 1'b1, ZERO, 4'b0100);
    add_row(MODE_DEC, ZERO, ZERO, 8'd0, 1'b1, MAXV, 4'b0101);
    // compare and undefined codes give a zero result with live flags
    add_row(MODE_CMP, 128'd5, 128'd9, 8'd0, 1'b1, ZERO, 4'b1001);
    add_row(MODE_CMP, MAXV, ZERO, 8'd7, 1'b1, ZERO, 4'b0010);
    add_row(MODE_UNUSED_LO, MAXV, ONE, 8'd0, 1'b1, ZERO, 4'b0010);
    add_row(MODE_UNUSED_HI, ZERO, MAXV, 8'd0, 1'b1, ZERO, 4'b1001);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_ops[i]) begin
      offer_op(directed_ops[i].op, directed_ops[i].known, directed_ops[i].res);
    end

    // random traffic with idling on both sides
    repeat (200) offer_op(random_op(), 1'b0, unused_res);

    // back-to-back stretch, no idling anywhere
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    repeat (150) offer_op(random_op(), 1'b0, unused_res);
    rx_steady = 1'b0;

    // result side holds off while operands keep coming, so the pipe backs up
    rx_hold_req = 1'b1;
    repeat (60) offer_op(random_op(), 1'b0, unused_res);
    tx_steady = 1'b0;

    // sender pauses until the pipe has fully drained
    in_ch.valid <= 1'b0;
    while (alu_results_due.size() != 0) @(posedge clk);

    repeat (240) offer_op(random_op(), 1'b0, unused_res);
    in_ch.valid <= 1'b0;

    while (alu_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (alu_results_due.size() != 0) begin
      $error("%0d expected results never arrived", alu_results_due.size());
      fail_count++;
    end
    $display("%0d operand transactions (%0d from the directed table) over all modes,",
             ops_accepted, directed_ops.size());
    $display("shift edges and unused codes; %0d results checked across a %0d-cycle hold-off",
             results_checked, LONG_HOLD);
    if (fail_count == 0) begin
      $display("wide_integer_alu_128: match");
    end else begin
      $display("wide_integer_alu_128: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
design/wia_pkg.sv
design/wia_in_if.sv
design/wia_out_if.sv
design/wia_mul.sv
design/wia_ops.sv
design/wide_integer_alu_128.sv
bench/tb_wide_integer_alu_128.sv
